FILE: rtl/mahony_pkg.sv
// ----------------------------------------------------------------------------
// mahony_pkg: shared types and constants of the Mahony attitude filter
// Q16.16 payload structs, register indexes, sequencer opcodes.
// ----------------------------------------------------------------------------
package mahony_pkg;

    localparam int unsigned FracBits   = 16;
    localparam logic [31:0] FixOne     = 32'd65536;
    localparam logic [30:0] StepReset  = 31'd655;
    localparam logic [30:0] PropReset  = 31'd65536;
    localparam logic [30:0] IntegReset = 31'd0;

    localparam logic [1:0] RegProp  = 2'd0;
    localparam logic [1:0] RegInteg = 2'd1;
    localparam logic [1:0] RegStep  = 2'd2;

    localparam logic OpUpdate = 1'b0;
    localparam logic OpReset  = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
    } t_out_item;

    // Divider command and status between sequencer and divider
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic        start;
        logic [31:0] val;
    } t_sqrt_req;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } t_sqrt_rsp;

    // Fixed-point multiply: 64-bit product >> 16, low 32 bits kept
    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        logic signed [63:0] p;
        p = $signed(a) * $signed(b);
        return p[47:16];
    endfunction

endpackage

FILE: rtl/mahony_imu_attitude_filter.sv
// ----------------------------------------------------------------------------
// mahony_imu_attitude_filter: Q16.16 Mahony attitude filter for a 6-axis IMU
//
// Input channel (i_in_valid / o_in_stall, payload i_in_item) carries one
// gyro plus accelerometer sample or an identity-restore opcode. Each item
// yields one quaternion on the output channel (o_out_valid / i_out_stall,
// payload o_out_item). Gains and the time step are written over the APB port.
// The block works on one item at a time with a shared 32x32 multiplier, a
// bit-serial divider (48 iterations per divide) and a bit-serial square
// root. An update with nonzero acceleration and both gains nonzero uses
// seven divides, two roots and 41 multiplier steps; a zero gain skips its
// integral or proportional steps, and zero acceleration skips the accel
// normalisation and the error steps. A restore opcode goes straight to the
// output step. The input stalls from acceptance until the result has been
// transferred.
// Reset restores the identity quaternion, clears the integral and loads the
// register defaults. A stalled result holds in the output register; the
// next item is taken only after it has been transferred.
// ----------------------------------------------------------------------------
module mahony_imu_attitude_filter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  mahony_pkg::t_in_item       i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output mahony_pkg::t_out_item      o_out_item,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [3:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_ANORM = 11'b00000000010,
        S_ASQRT = 11'b00000000100,
        S_ADIV  = 11'b00000001000,
        S_MUL   = 11'b00000010000,
        S_QSQ   = 11'b00000100000,
        S_QSQRT = 11'b00001000000,
        S_QDIV  = 11'b00010000000,
        S_WAIT  = 11'b00100000000,
        S_OUT   = 11'b01000000000,
        S_START = 11'b10000000000
    } t_state;

    t_state r_state;
    logic [30:0] r_prop, r_integ, r_step;
    logic [31:0] r_q [4];
    logic [31:0] r_ei [3];
    logic [31:0] r_g [3];
    logic [31:0] r_a [3];
    logic [31:0] r_v [3];
    logic [31:0] r_e [3];
    logic [31:0] r_t [4];
    logic [31:0] r_nq [4];
    logic [63:0] r_sum;
    logic [31:0] r_norm;
    logic [1:0]  r_idx;
    logic [5:0]  r_step_no;
    logic        r_busy_div, r_busy_sq;
    logic        r_out_valid;
    mahony_pkg::t_out_item r_out;

    mahony_pkg::t_div_req  div_req;
    mahony_pkg::t_div_rsp  div_rsp;
    mahony_pkg::t_sqrt_req sq_req;
    mahony_pkg::t_sqrt_rsp sq_rsp;

    mahony_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));
    mahony_sqrt u_sqrt (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(sq_req), .o_rsp(sq_rsp));

    logic in_fire, out_fire, cfg_wr;
    assign in_fire  = i_in_valid && !o_in_stall;
    assign out_fire = r_out_valid && !i_out_stall;
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE) || r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Register readback
    always_comb begin
        case (paddr[3:2])
            mahony_pkg::RegProp:  prdata = {1'b0, r_prop};
            mahony_pkg::RegInteg: prdata = {1'b0, r_integ};
            mahony_pkg::RegStep:  prdata = {1'b0, r_step};
            default:              prdata = 32'd0;
        endcase
    end

    // Shared multiplier operands, chosen by the micro-step counter
    logic [31:0] ma, mb, mp;
    logic [31:0] hdt;
    assign hdt = {1'b0, r_step} >> 1;
    assign mp  = mahony_pkg::fmul(ma, mb);

    // Micro-step list in S_MUL:
    //  0..9  : products for v (q1q3, q0q2, q0q1, q2q3, q0q0, q1q1, q2q2, q3q3)
    //  10..15: cross products a x v
    //  16..21: integral (e*dt, ki*ei)
    //  22..24: proportional (kp*e)
    //  25..36: quaternion derivative terms
    //  37..40: times hdt
    always_comb begin
        ma = 32'd0;
        mb = 32'd0;
        case (r_step_no)
            6'd0:  begin ma = r_q[1]; mb = r_q[3]; end
            6'd1:  begin ma = r_q[0]; mb = r_q[2]; end
            6'd2:  begin ma = r_q[0]; mb = r_q[1]; end
            6'd3:  begin ma = r_q[2]; mb = r_q[3]; end
            6'd4:  begin ma = r_q[0]; mb = r_q[0]; end
            6'd5:  begin ma = r_q[1]; mb = r_q[1]; end
            6'd6:  begin ma = r_q[2]; mb = r_q[2]; end
            6'd7:  begin ma = r_q[3]; mb = r_q[3]; end
            6'd8:  begin ma = 32'h00020000; mb = r_t[0]; end
            6'd9:  begin ma = 32'h00020000; mb = r_t[1]; end
            6'd10: begin ma = r_a[1]; mb = r_v[2]; end
            6'd11: begin ma = r_a[2]; mb = r_v[1]; end
            6'd12: begin ma = r_a[2]; mb = r_v[0]; end
            6'd13: begin ma = r_a[0]; mb = r_v[2]; end
            6'd14: begin ma = r_a[0]; mb = r_v[1]; end
            6'd15: begin ma = r_a[1]; mb = r_v[0]; end
            6'd16: begin ma = r_e[0]; mb = {1'b0, r_step}; end
            6'd17: begin ma = {1'b0, r_integ}; mb = r_ei[0]; end
            6'd18: begin ma = r_e[1]; mb = {1'b0, r_step}; end
            6'd19: begin ma = {1'b0, r_integ}; mb = r_ei[1]; end
            6'd20: begin ma = r_e[2]; mb = {1'b0, r_step}; end
            6'd21: begin ma = {1'b0, r_integ}; mb = r_ei[2]; end
            6'd22: begin ma = {1'b0, r_prop}; mb = r_e[0]; end
            6'd23: begin ma = {1'b0, r_prop}; mb = r_e[1]; end
            6'd24: begin ma = {1'b0, r_prop}; mb = r_e[2]; end
            6'd25: begin ma = r_q[1]; mb = r_g[0]; end
            6'd26: begin ma = r_q[2]; mb = r_g[1]; end
            6'd27: begin ma = r_q[3]; mb = r_g[2]; end
            6'd28: begin ma = r_q[0]; mb = r_g[0]; end
            6'd29: begin ma = r_q[2]; mb = r_g[2]; end
            6'd30: begin ma = r_q[3]; mb = r_g[1]; end
            6'd31: begin ma = r_q[0]; mb = r_g[1]; end
            6'd32: begin ma = r_q[1]; mb = r_g[2]; end
            6'd33: begin ma = r_q[3]; mb = r_g[0]; end
            6'd34: begin ma = r_q[0]; mb = r_g[2]; end
            6'd35: begin ma = r_q[1]; mb = r_g[1]; end
            6'd36: begin ma = r_q[2]; mb = r_g[0]; end
            6'd37: begin ma = r_t[0]; mb = hdt; end
            6'd38: begin ma = r_t[1]; mb = hdt; end
            6'd39: begin ma = r_t[2]; mb = hdt; end
            6'd40: begin ma = r_t[3]; mb = hdt; end
            default: begin ma = 32'd0; mb = 32'd0; end
        endcase
    end

    // Square of the selected element for the norm sums
    logic [31:0] sq_src;
    logic signed [63:0] sq_val;
    logic [63:0] sum_next;
    logic [31:0] sum_sat;
    always_comb begin
        if (r_state == S_ANORM) begin
            sq_src = (r_idx == 2'd0) ? r_a[0] : (r_idx == 2'd1) ? r_a[1] : r_a[2];
        end else begin
            sq_src = r_nq[r_idx];
        end
        sq_val   = $signed(sq_src) * $signed(sq_src);
        sum_next = r_sum + sq_val;
        sum_sat  = (r_sum[63:47] != 17'd0) ? 32'h7FFFFFFF : {1'b0, r_sum[46:16]};
    end

    // Divide starts in S_START on a nonzero norm; a root once the full nonzero square sum is held
    assign div_req.start = (r_state == S_START) && (r_norm != 32'd0);
    assign div_req.num   = r_busy_sq ? r_nq[r_idx] : r_a[r_idx];
    assign div_req.den   = r_norm;
    assign sq_req.start  = (((r_state == S_ANORM) && (r_idx == 2'd3)) || (r_state == S_WAIT))
                           && (sum_sat != 32'd0);
    assign sq_req.val    = sum_sat;

    // Skipped steps: integral when gain is zero, proportional when zero
    logic [5:0] next_no;
    always_comb begin
        next_no = r_step_no + 6'd1;
        if (r_step_no == 6'd15 && r_integ == 31'd0) begin
            next_no = 6'd22;
        end
        if ((next_no == 6'd22) && r_prop == 31'd0) begin
            next_no = 6'd25;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_prop      <= mahony_pkg::PropReset;
            r_integ     <= mahony_pkg::IntegReset;
            r_step      <= mahony_pkg::StepReset;
            r_q[0] <= mahony_pkg::FixOne;
            r_q[1] <= 32'd0;
            r_q[2] <= 32'd0;
            r_q[3] <= 32'd0;
            r_ei[0] <= 32'd0;
            r_ei[1] <= 32'd0;
            r_ei[2] <= 32'd0;
            r_idx <= 2'd0;
            r_step_no <= 6'd0;
            r_busy_div <= 1'b0;
            r_busy_sq <= 1'b0;
        end else begin
            // Configuration writes
            if (cfg_wr) begin
                case (paddr[3:2])
                    mahony_pkg::RegProp:  r_prop  <= pwdata[30:0];
                    mahony_pkg::RegInteg: r_integ <= pwdata[30:0];
                    mahony_pkg::RegStep:  r_step  <= (pwdata[30:0] == 31'd0) ?
                                                     mahony_pkg::StepReset : pwdata[30:0];
                    default: ;
                endcase
            end
            if (out_fire) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_in_item.opcode == mahony_pkg::OpReset) begin
                            r_q[0] <= mahony_pkg::FixOne;
                            r_q[1] <= 32'd0;
                            r_q[2] <= 32'd0;
                            r_q[3] <= 32'd0;
                            r_ei[0] <= 32'd0;
                            r_ei[1] <= 32'd0;
                            r_ei[2] <= 32'd0;
                            r_state <= S_OUT;
                        end else begin
                            r_g[0] <= i_in_item.rate_x;
                            r_g[1] <= i_in_item.rate_y;
                            r_g[2] <= i_in_item.rate_z;
                            r_a[0] <= i_in_item.accel_x;
                            r_a[1] <= i_in_item.accel_y;
                            r_a[2] <= i_in_item.accel_z;
                            r_sum <= 64'd0;
                            r_idx <= 2'd0;
                            r_busy_sq <= 1'b0;
                            r_state <= S_ANORM;
                        end
                    end
                end
                // Accumulate accel squares, then start the root, or skip to the quaternion steps if the sum is zero
                S_ANORM: begin
                    if (r_idx == 2'd3) begin
                        r_state <= (sum_sat == 32'd0) ? S_MUL : S_ASQRT;
                        r_step_no <= (sum_sat == 32'd0) ? 6'd25 : 6'd0;
                    end else begin
                        r_sum <= sum_next;
                        r_idx <= r_idx + 2'd1;
                    end
                end
                S_ASQRT: begin
                    if (sq_rsp.done) begin
                        r_norm <= sq_rsp.root;
                        r_idx  <= 2'd0;
                        r_state <= S_START;
                    end
                end
                // Launch one divide of the current element
                S_START: begin
                    r_state <= r_busy_sq ? S_QDIV : S_ADIV;
                end
                S_ADIV: begin
                    if (div_rsp.done) begin
                        r_a[r_idx] <= div_rsp.quo;
                        if (r_idx == 2'd2) begin
                            r_step_no <= 6'd0;
                            r_state <= S_MUL;
                        end else begin
                            r_idx <= r_idx + 2'd1;
                            r_state <= S_START;
                        end
                    end
                end
                // One product per cycle through the shared multiplier
                S_MUL: begin
                    r_step_no <= next_no;
                    case (r_step_no)
                        6'd0: r_t[0] <= mp;
                        6'd1: r_t[0] <= r_t[0] - mp;
                        6'd2: r_t[1] <= mp;
                        6'd3: r_t[1] <= r_t[1] + mp;
                        6'd4: r_v[2] <= mp;
                        6'd5: r_v[2] <= r_v[2] - mp;
                        6'd6: r_v[2] <= r_v[2] - mp;
                        6'd7: r_v[2] <= r_v[2] + mp;
                        6'd8: r_v[0] <= mp;
                        6'd9: r_v[1] <= mp;
                        6'd10: r_e[0] <= mp;
                        6'd11: r_e[0] <= r_e[0] - mp;
                        6'd12: r_e[1] <= mp;
                        6'd13: r_e[1] <= r_e[1] - mp;
                        6'd14: r_e[2] <= mp;
                        6'd15: r_e[2] <= r_e[2] - mp;
                        6'd16: r_ei[0] <= r_ei[0] + mp;
                        6'd17: r_g[0] <= r_g[0] + mp;
                        6'd18: r_ei[1] <= r_ei[1] + mp;
                        6'd19: r_g[1] <= r_g[1] + mp;
                        6'd20: r_ei[2] <= r_ei[2] + mp;
                        6'd21: r_g[2] <= r_g[2] + mp;
                        6'd22: r_g[0] <= r_g[0] + mp;
                        6'd23: r_g[1] <= r_g[1] + mp;
                        6'd24: r_g[2] <= r_g[2] + mp;
                        6'd25: r_t[0] <= 32'd0 - mp;
                        6'd26: r_t[0] <= r_t[0] - mp;
                        6'd27: r_t[0] <= r_t[0] - mp;
                        6'd28: r_t[1] <= mp;
                        6'd29: r_t[1] <= r_t[1] + mp;
                        6'd30: r_t[1] <= r_t[1] - mp;
                        6'd31: r_t[2] <= mp;
                        6'd32: r_t[2] <= r_t[2] - mp;
                        6'd33: r_t[2] <= r_t[2] + mp;
                        6'd34: r_t[3] <= mp;
                        6'd35: r_t[3] <= r_t[3] + mp;
                        6'd36: r_t[3] <= r_t[3] - mp;
                        6'd37: r_nq[0] <= r_q[0] + mp;
                        6'd38: r_nq[1] <= r_q[1] + mp;
                        6'd39: r_nq[2] <= r_q[2] + mp;
                        6'd40: begin
                            r_nq[3] <= r_q[3] + mp;
                            r_sum <= 64'd0;
                            r_idx <= 2'd0;
                            r_state <= S_QSQ;
                        end
                        default: ;
                    endcase
                end
                // Accumulate the four quaternion squares
                S_QSQ: begin
                    r_sum <= sum_next;
                    r_idx <= r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        r_busy_sq <= 1'b1;
                        r_state <= S_WAIT;
                    end
                end
                // Wait so the fourth square lands before the root starts; a zero sum skips the root and divides
                S_WAIT: begin
                    if (sum_sat == 32'd0) begin
                        r_q <= r_nq;
                        r_busy_sq <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_QSQRT;
                        r_busy_div <= 1'b1;
                    end
                end
                S_QSQRT: begin
                    if (r_busy_div) begin
                        r_busy_div <= 1'b0;
                    end else if (sq_rsp.done) begin
                        r_norm <= sq_rsp.root;
                        r_idx  <= 2'd0;
                        r_state <= S_START;
                    end
                end
                S_QDIV: begin
                    if (div_rsp.done) begin
                        r_nq[r_idx] <= div_rsp.quo;
                        if (r_idx == 2'd3) begin
                            r_busy_sq <= 1'b0;
                            r_q[0] <= (r_idx == 2'd0) ? div_rsp.quo : r_nq[0];
                            r_q[1] <= r_nq[1];
                            r_q[2] <= r_nq[2];
                            r_q[3] <= div_rsp.quo;
                            r_state <= S_OUT;
                        end else begin
                            r_idx <= r_idx + 2'd1;
                            r_state <= S_START;
                        end
                    end
                end
                // Present the stored quaternion
                S_OUT: begin
                    r_out_valid <= 1'b1;
                    r_out.quat_w <= r_q[0];
                    r_out.quat_x <= r_q[1];
                    r_out.quat_y <= r_q[2];
                    r_out.quat_z <= r_q[3];
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A divide start is never followed at once by a done flag from the divider
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> !div_rsp.done)
        else $error("divider done overlapped a start");
    // No new item while a result is still held
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while result stalled");
    // A result is raised only from the output step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside output step");
endmodule

FILE: rtl/mahony_div.sv
// ----------------------------------------------------------------------------
// mahony_div: restoring divider, one quotient bit per cycle
// Computes trunc((num * 65536) / den) for den > 0, low 32 bits.
// ----------------------------------------------------------------------------
module mahony_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mahony_pkg::t_div_req  i_req,
    output mahony_pkg::t_div_rsp  o_rsp
);
    logic        r_busy, n_busy;
    logic [5:0]  r_cnt, n_cnt;
    logic [47:0] r_num, n_num;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic        r_neg, n_neg;
    logic        r_done, n_done;
    logic [31:0] quo_mag;
    logic [32:0] shifted;
    logic [32:0] diff;

    // Shift one numerator bit into the remainder and try a subtract
    always_comb begin
        shifted = {r_rem[31:0], r_num[47]};
        diff    = shifted - {1'b0, r_den};
        quo_mag = r_num[31:0];
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        n_neg  = r_neg;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd0;
            n_neg  = i_req.num[31];
            n_num  = {(i_req.num[31] ? (32'd0 - i_req.num) : i_req.num), 16'd0};
            n_rem  = 33'd0;
            n_den  = i_req.den;
        end else if (r_busy) begin
            if (!diff[32]) begin
                n_rem = diff;
            end else begin
                n_rem = shifted;
            end
            n_num = {r_num[46:0], ~diff[32]};
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd47) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? (32'd0 - quo_mag) : quo_mag;
endmodule

FILE: rtl/mahony_sqrt.sv
// ----------------------------------------------------------------------------
// mahony_sqrt: digit-by-digit integer square root, one result bit per cycle
// Computes floor(sqrt(val * 65536)) for a 31-bit value.
// ----------------------------------------------------------------------------
module mahony_sqrt (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mahony_pkg::t_sqrt_req  i_req,
    output mahony_pkg::t_sqrt_rsp  o_rsp
);
    logic        r_busy, n_busy;
    logic [4:0]  r_cnt, n_cnt;
    logic [47:0] r_x, n_x;
    logic [33:0] r_rem, n_rem;
    logic [31:0] r_root, n_root;
    logic        r_done, n_done;
    logic [33:0] trial;
    logic [33:0] cur;

    // Bring down two radicand bits and test the next root bit
    always_comb begin
        cur   = {r_rem[31:0], r_x[47:46]};
        trial = {r_root, 2'b01};
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_rem  = r_rem;
        n_root = r_root;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd0;
            n_x    = {1'b0, i_req.val[30:0], 16'd0};
            n_rem  = 34'd0;
            n_root = 32'd0;
        end else if (r_busy) begin
            n_x = {r_x[45:0], 2'b00};
            if (cur >= trial) begin
                n_rem  = cur - trial;
                n_root = {r_root[30:0], 1'b1};
            end else begin
                n_rem  = cur;
                n_root = {r_root[30:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd23) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_x    <= n_x;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;
endmodule
